### design/kcsi_pkg.sv
// ----------------------------------------------------------------------------
// kcsi_pkg: shared constants and types of the keyframe interpolator
// Key count, blend precision, register map and the records that travel
// between the configuration, front, queue and back parts.
// ----------------------------------------------------------------------------
package kcsi_pkg;

  localparam int KEY_COUNT   = 4;
  localparam int FRAC_BITS   = 16;
  localparam int TIME_W      = 16;
  localparam int SIZE_W      = 16;
  localparam int CHAN_W      = 8;
  localparam int CHANNELS    = 4;
  localparam int BLEND_W     = FRAC_BITS + 1;
  localparam int SHORT_SPAN  = 6;
  localparam int QUEUE_DEPTH = 2;

  // one quotient bit per divider stage, the first one taken at queue pop
  localparam int DIV_STAGES  = FRAC_BITS + 1;

  localparam int COLOR_PROD_W = CHAN_W + BLEND_W;
  localparam int SIZE_PROD_W  = SIZE_W + BLEND_W;

  localparam logic [BLEND_W-1:0] BLEND_ONE = BLEND_W'(1) << FRAC_BITS;

  // register map, byte address 8 * index
  localparam int ADDR_W   = 6;
  localparam int DATA_W   = 64;
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_KEY_TIMES  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_KEY_SIZES  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_KEY0_COLOR = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_KEY1_COLOR = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_KEY2_COLOR = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_KEY3_COLOR = 3'd5;

  typedef struct packed {
    logic [KEY_COUNT-1:0][TIME_W-1:0]            times;
    logic [KEY_COUNT-1:0][SIZE_W-1:0]            sizes;
    logic [KEY_COUNT-1:0][CHANNELS*CHAN_W-1:0]   colors;
  } cfg_t;

  typedef struct packed {
    logic [CHANNELS-1:0][CHAN_W-1:0] color;
    logic [SIZE_W-1:0]               size;
  } key_val_t;

  // classified item: blend numerator and span plus the two keys to mix
  typedef struct packed {
    logic [TIME_W-1:0] diff;
    logic [TIME_W-1:0] span;
    logic              short_span;
    key_val_t          a;
    key_val_t          b;
  } job_t;

  typedef struct packed {
    logic [TIME_W-1:0]  rem;
    logic [BLEND_W-1:0] quo;
    logic [TIME_W-1:0]  span;
    logic               short_span;
    key_val_t           a;
    key_val_t           b;
  } div_t;

  typedef struct packed {
    logic [CHANNELS-1:0]                   ge_col;
    logic                                  ge_size;
    key_val_t                              a;
    logic [CHANNELS-1:0][COLOR_PROD_W-1:0] prod_col;
    logic [SIZE_PROD_W-1:0]                prod_size;
  } mul_t;

endpackage

### design/kcsi_regs.sv
// ----------------------------------------------------------------------------
// kcsi_regs: configuration registers
// APB-style write and read of key times, key sizes and the four key colors.
// ----------------------------------------------------------------------------
module kcsi_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kcsi_pkg::ADDR_W-1:0]   paddr,
  input  logic [kcsi_pkg::DATA_W-1:0]   pwdata,
  output logic [kcsi_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output kcsi_pkg::cfg_t                cfg_o
);

  kcsi_pkg::cfg_t cfg_q;
  logic [kcsi_pkg::REG_IDX_W-1:0] idx;
  logic wr_en;

  assign idx    = paddr[kcsi_pkg::ADDR_W-1:3];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.times  <= '0;
      cfg_q.sizes  <= '0;
      cfg_q.colors <= '1;
    end else if (wr_en) begin
      unique case (idx)
        kcsi_pkg::REG_KEY_TIMES:  cfg_q.times     <= pwdata;
        kcsi_pkg::REG_KEY_SIZES:  cfg_q.sizes     <= pwdata;
        kcsi_pkg::REG_KEY0_COLOR: cfg_q.colors[0] <= pwdata[31:0];
        kcsi_pkg::REG_KEY1_COLOR: cfg_q.colors[1] <= pwdata[31:0];
        kcsi_pkg::REG_KEY2_COLOR: cfg_q.colors[2] <= pwdata[31:0];
        kcsi_pkg::REG_KEY3_COLOR: cfg_q.colors[3] <= pwdata[31:0];
        default: ;  // drop writes to unmapped addresses
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      kcsi_pkg::REG_KEY_TIMES:  prdata = cfg_q.times;
      kcsi_pkg::REG_KEY_SIZES:  prdata = cfg_q.sizes;
      kcsi_pkg::REG_KEY0_COLOR: prdata = {32'h0, cfg_q.colors[0]};
      kcsi_pkg::REG_KEY1_COLOR: prdata = {32'h0, cfg_q.colors[1]};
      kcsi_pkg::REG_KEY2_COLOR: prdata = {32'h0, cfg_q.colors[2]};
      kcsi_pkg::REG_KEY3_COLOR: prdata = {32'h0, cfg_q.colors[3]};
      default:                  prdata = '0;
    endcase
  end

endmodule

### design/kcsi_front.sv
// ----------------------------------------------------------------------------
// kcsi_front: segment classification
// Find the key segment of a life fraction and build the division job.
// ----------------------------------------------------------------------------
module kcsi_front (
  input  logic [kcsi_pkg::TIME_W-1:0] life_fraction_i,
  input  kcsi_pkg::cfg_t              cfg_i,
  output kcsi_pkg::job_t              job_o
);

  function automatic kcsi_pkg::key_val_t key_of(input kcsi_pkg::cfg_t cfg, input int k);
    kcsi_pkg::key_val_t kv;
    kv.color = cfg.colors[k];
    kv.size  = cfg.sizes[k];
    return kv;
  endfunction

  always_comb begin
    logic found;
    logic [kcsi_pkg::TIME_W-1:0] span;
    found = 1'b0;
    span  = '0;
    // above the last key time: hold the last key
    job_o.diff       = '0;
    job_o.span       = '0;
    job_o.short_span = 1'b1;
    job_o.a          = key_of(cfg_i, kcsi_pkg::KEY_COUNT-1);
    job_o.b          = key_of(cfg_i, kcsi_pkg::KEY_COUNT-1);
    if (life_fraction_i <= cfg_i.times[0]) begin
      job_o.a = key_of(cfg_i, 0);
      job_o.b = key_of(cfg_i, 0);
    end else begin
      for (int k = 1; k < kcsi_pkg::KEY_COUNT; k++) begin
        if (!found && (life_fraction_i <= cfg_i.times[k])) begin
          found            = 1'b1;
          span             = cfg_i.times[k] - cfg_i.times[k-1];
          job_o.diff       = life_fraction_i - cfg_i.times[k-1];
          job_o.span       = span;
          job_o.short_span = (span <= kcsi_pkg::TIME_W'(kcsi_pkg::SHORT_SPAN));
          job_o.a          = key_of(cfg_i, k-1);
          job_o.b          = key_of(cfg_i, k);
        end
      end
    end
  end

endmodule

### design/kcsi_queue.sv
// ----------------------------------------------------------------------------
// kcsi_queue: job queue
// Short FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module kcsi_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  kcsi_pkg::job_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output kcsi_pkg::job_t data_o
);

  localparam int PTR_W = $clog2(kcsi_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(kcsi_pkg::QUEUE_DEPTH + 1);

  kcsi_pkg::job_t mem_q [kcsi_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(kcsi_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full_o  = (count_q == CNT_W'(kcsi_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + CNT_W'(1);
        2'b01:   count_q <= count_q - CNT_W'(1);
        default: ;
      endcase
    end
  end

endmodule

### design/kcsi_back.sv
// ----------------------------------------------------------------------------
// kcsi_back: blend divider and channel mixer
// Restoring divider one quotient bit per stage, then multiply and mix.
// ----------------------------------------------------------------------------
module kcsi_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         empty_i,
  input  kcsi_pkg::job_t               job_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [kcsi_pkg::CHAN_W-1:0]  red_o,
  output logic [kcsi_pkg::CHAN_W-1:0]  green_o,
  output logic [kcsi_pkg::CHAN_W-1:0]  blue_o,
  output logic [kcsi_pkg::CHAN_W-1:0]  alpha_o,
  output logic [kcsi_pkg::SIZE_W-1:0]  particle_size_o
);

  localparam int NS = kcsi_pkg::DIV_STAGES;

  kcsi_pkg::div_t div_q [NS];
  logic [NS-1:0]  div_vld_q;
  kcsi_pkg::mul_t mul_q, mul_d;
  logic           mul_vld_q;
  kcsi_pkg::key_val_t res_q, res_d;
  logic           out_valid_q;
  logic           adv;
  kcsi_pkg::div_t div_d [NS];

  // whole pipeline moves unless a finished word is held at the output
  assign adv   = !out_valid_q || !out_stall_i;
  assign pop_o = adv && !empty_i;

  always_comb begin
    logic ge;
    logic [kcsi_pkg::TIME_W:0] r2;
    // first quotient bit: diff never exceeds span, so it is 0 or 1
    ge = (job_i.diff >= job_i.span);
    div_d[0].rem        = ge ? job_i.diff - job_i.span : job_i.diff;
    div_d[0].quo        = kcsi_pkg::BLEND_W'(ge);
    div_d[0].span       = job_i.span;
    div_d[0].short_span = job_i.short_span;
    div_d[0].a          = job_i.a;
    div_d[0].b          = job_i.b;
    for (int i = 1; i < NS; i++) begin
      r2 = {div_q[i-1].rem, 1'b0};
      ge = (r2 >= {1'b0, div_q[i-1].span});
      div_d[i]     = div_q[i-1];
      div_d[i].rem = ge ? kcsi_pkg::TIME_W'(r2 - {1'b0, div_q[i-1].span})
                        : kcsi_pkg::TIME_W'(r2);
      div_d[i].quo = {div_q[i-1].quo[kcsi_pkg::BLEND_W-2:0], ge};
    end
  end

  always_comb begin
    logic [kcsi_pkg::BLEND_W-1:0] blend;
    logic [kcsi_pkg::CHAN_W-1:0]  ca, cb, cmag;
    logic [kcsi_pkg::SIZE_W-1:0]  smag;
    kcsi_pkg::div_t               last;
    last  = div_q[NS-1];
    blend = last.short_span ? kcsi_pkg::BLEND_ONE : last.quo;
    mul_d.a = last.a;
    for (int c = 0; c < kcsi_pkg::CHANNELS; c++) begin
      ca = last.a.color[c];
      cb = last.b.color[c];
      mul_d.ge_col[c]   = (cb >= ca);
      cmag              = (cb >= ca) ? cb - ca : ca - cb;
      mul_d.prod_col[c] = kcsi_pkg::COLOR_PROD_W'(cmag) * kcsi_pkg::COLOR_PROD_W'(blend);
    end
    mul_d.ge_size   = (last.b.size >= last.a.size);
    smag            = mul_d.ge_size ? last.b.size - last.a.size : last.a.size - last.b.size;
    mul_d.prod_size = kcsi_pkg::SIZE_PROD_W'(smag) * kcsi_pkg::SIZE_PROD_W'(blend);
  end

  always_comb begin
    logic [kcsi_pkg::COLOR_PROD_W:0] csum;
    logic [kcsi_pkg::SIZE_PROD_W:0]  ssum;
    logic [kcsi_pkg::CHAN_W-1:0]     cstep;
    logic [kcsi_pkg::SIZE_W-1:0]     sstep;
    // round the step up on a falling segment: floor toward minus infinity
    for (int c = 0; c < kcsi_pkg::CHANNELS; c++) begin
      csum = {1'b0, mul_q.prod_col[c]}
           + (kcsi_pkg::COLOR_PROD_W+1)'(mul_q.ge_col[c] ? 0 : (1 << kcsi_pkg::FRAC_BITS) - 1);
      cstep = kcsi_pkg::CHAN_W'(csum >> kcsi_pkg::FRAC_BITS);
      res_d.color[c] = mul_q.ge_col[c] ? mul_q.a.color[c] + cstep : mul_q.a.color[c] - cstep;
    end
    ssum = {1'b0, mul_q.prod_size}
         + (kcsi_pkg::SIZE_PROD_W+1)'(mul_q.ge_size ? 0 : (1 << kcsi_pkg::FRAC_BITS) - 1);
    sstep = kcsi_pkg::SIZE_W'(ssum >> kcsi_pkg::FRAC_BITS);
    res_d.size = mul_q.ge_size ? mul_q.a.size + sstep : mul_q.a.size - sstep;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < NS; i++) begin
        div_q[i] <= div_d[i];
      end
      mul_q <= mul_d;
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_vld_q   <= '0;
      mul_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      div_vld_q   <= {div_vld_q[NS-2:0], !empty_i};
      mul_vld_q   <= div_vld_q[NS-1];
      out_valid_q <= mul_vld_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign red_o           = res_q.color[0];
  assign green_o         = res_q.color[1];
  assign blue_o          = res_q.color[2];
  assign alpha_o         = res_q.color[3];
  assign particle_size_o = res_q.size;

endmodule

### design/keyframe_color_size_interpolator.sv
// ----------------------------------------------------------------------------
// keyframe_color_size_interpolator: particle color and size from life fraction
// Piecewise linear blend between four configured keys.
// ----------------------------------------------------------------------------
// One word in and one word out per clock cycle, sustained while the output
// is not stalled. Behind the job queue each word passes the blend divider,
// which produces one quotient bit per stage over 17 stages, then one multiply
// stage and one mix stage at the output. Configuration is written through
// the APB-style port at byte address 8 * register index and must only change
// while no word is in flight.
// ----------------------------------------------------------------------------
module keyframe_color_size_interpolator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [kcsi_pkg::ADDR_W-1:0]  paddr,
  input  logic [kcsi_pkg::DATA_W-1:0]  pwdata,
  output logic [kcsi_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  // input words
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [kcsi_pkg::TIME_W-1:0]  life_fraction_i,
  // result words
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [kcsi_pkg::CHAN_W-1:0]  red_o,
  output logic [kcsi_pkg::CHAN_W-1:0]  green_o,
  output logic [kcsi_pkg::CHAN_W-1:0]  blue_o,
  output logic [kcsi_pkg::CHAN_W-1:0]  alpha_o,
  output logic [kcsi_pkg::SIZE_W-1:0]  particle_size_o
);

  kcsi_pkg::cfg_t cfg;
  kcsi_pkg::job_t front_job, queue_job;
  logic           queue_full, queue_empty, pop, push;

  kcsi_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Classify the incoming fraction: pick the segment, its span and keys.
  kcsi_front u_front (
    .life_fraction_i (life_fraction_i),
    .cfg_i           (cfg),
    .job_o           (front_job)
  );

  // Accept whenever the queue has room; the back part drains it on its own.
  assign in_stall_o = queue_full;
  assign push       = in_valid_i && !queue_full;

  kcsi_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_job),
    .full_o  (queue_full),
    .pop_i   (pop),
    .empty_o (queue_empty),
    .data_o  (queue_job)
  );

  // Divide, multiply and mix; hold everything while the output word waits.
  kcsi_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (queue_empty),
    .job_i           (queue_job),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .red_o           (red_o),
    .green_o         (green_o),
    .blue_o          (blue_o),
    .alpha_o         (alpha_o),
    .particle_size_o (particle_size_o)
  );

endmodule

### bench/keyframe_color_size_interpolator_tb.sv
// ----------------------------------------------------------------------------
// keyframe_color_size_interpolator_tb: self-checking bench of the interpolator
// Programs the key registers over the APB-style port, streams life fractions
// with random gaps and output stalls, and compares every result word with a
// color and size prediction made at the moment the input word is accepted.
// ----------------------------------------------------------------------------
module keyframe_color_size_interpolator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kcsi_pkg::*;

  // indexes beyond the register map; writes there must change nothing
  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

  localparam int RESET_CYCLES  = 7;
  localparam int HOLD_CYCLES   = 200;   // long receiver hold-off
  localparam int IDLE_LIMIT    = 2000;  // cycles without any handshake
  localparam int SETTLE_CYCLES = 40;    // about twice the pipeline depth
  localparam int PHASE_WORDS   = 105;
  localparam int REPORT_MAX    = 10;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
    logic [SIZE_W-1:0] particle_size;
  } shade_t;

  logic                clk_i   = 1'b0;
  logic                rst_ni  = 1'b0;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [ADDR_W-1:0]   paddr   = '0;
  logic [DATA_W-1:0]   pwdata  = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid_i      = 1'b0;
  logic                in_stall_o;
  logic [TIME_W-1:0]   life_fraction_i = '0;
  logic                out_valid_o;
  logic                out_stall_i     = 1'b0;
  logic [CHAN_W-1:0]   red_o;
  logic [CHAN_W-1:0]   green_o;
  logic [CHAN_W-1:0]   blue_o;
  logic [CHAN_W-1:0]   alpha_o;
  logic [SIZE_W-1:0]   particle_size_o;

  // shadow copy of the key registers, as they read after reset
  logic [DATA_W-1:0]   key_times_cfg = '0;
  logic [DATA_W-1:0]   key_sizes_cfg = '0;
  logic [31:0]         key_color_cfg [KEY_COUNT] = '{default: 32'hFFFF_FFFF};

  logic [TIME_W-1:0]   pending_fractions [$];
  shade_t              expected_shades [$];

  int                  send_idle_pct = 0;
  int                  stall_pct     = 0;
  int                  failures      = 0;
  int                  idle_cycles   = 0;
  int                  hold_left     = 0;
  logic                hold_kick     = 1'b0;

  keyframe_color_size_interpolator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .life_fraction_i (life_fraction_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .red_o           (red_o),
    .green_o         (green_o),
    .blue_o          (blue_o),
    .alpha_o         (alpha_o),
    .particle_size_o (particle_size_o)
  );

  always #4 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // a + floor((b - a) * blend / 2^FRAC_BITS), floor toward minus infinity:
  // a falling channel rounds its step up so the result never undershoots b
  function automatic int unsigned lerp_channel(input int unsigned a,
                                               input int unsigned b,
                                               input longint unsigned blend);
    longint unsigned delta;
    longint unsigned step;
    if (b >= a) begin
      delta = b - a;
      step  = (delta * blend) >> FRAC_BITS;
      return a + int'(step);
    end
    delta = a - b;
    step  = (delta * blend + (longint'(1) << FRAC_BITS) - 1) >> FRAC_BITS;
    return a - int'(step);
  endfunction

  function automatic shade_t predict_shade(input logic [TIME_W-1:0] fraction);
    shade_t          shade;
    int unsigned     f;
    int unsigned     t_lo;
    int unsigned     t_hi;
    int unsigned     span;
    longint unsigned blend;
    int              ka;
    int              kb;
    logic            found;
    f     = fraction;
    ka    = KEY_COUNT - 1;
    kb    = KEY_COUNT - 1;
    blend = 0;
    found = 1'b0;
    // at or below the first key time: key 0 unchanged
    if (f <= key_times_cfg[TIME_W-1:0]) begin
      ka    = 0;
      kb    = 0;
      found = 1'b1;
    end
    // otherwise the first key whose time is not exceeded, blended with the
    // key before it; past the last key time the last key stands as is
    for (int k = 1; k < KEY_COUNT; k++) begin
      t_hi = key_times_cfg[TIME_W*k +: TIME_W];
      if (!found && f <= t_hi) begin
        t_lo  = key_times_cfg[TIME_W*(k-1) +: TIME_W];
        span  = t_hi - t_lo;
        ka    = k - 1;
        kb    = k;
        found = 1'b1;
        if (span > SHORT_SPAN)
          blend = (longint'(f - t_lo) << FRAC_BITS) / span;
        else
          blend = longint'(1) << FRAC_BITS;
      end
    end
    // blending a key with itself leaves it unchanged, so one path serves all
    shade.red   = CHAN_W'(lerp_channel(key_color_cfg[ka][7:0],
                                       key_color_cfg[kb][7:0], blend));
    shade.green = CHAN_W'(lerp_channel(key_color_cfg[ka][15:8],
                                       key_color_cfg[kb][15:8], blend));
    shade.blue  = CHAN_W'(lerp_channel(key_color_cfg[ka][23:16],
                                       key_color_cfg[kb][23:16], blend));
    shade.alpha = CHAN_W'(lerp_channel(key_color_cfg[ka][31:24],
                                       key_color_cfg[kb][31:24], blend));
    shade.particle_size = SIZE_W'(lerp_channel(key_sizes_cfg[SIZE_W*ka +: SIZE_W],
                                               key_sizes_cfg[SIZE_W*kb +: SIZE_W],
                                               blend));
    return shade;
  endfunction

  // random life fraction: often near a key time, else uniform or an extreme
  function automatic logic [TIME_W-1:0] pick_fraction();
    int k;
    k = $urandom_range(KEY_COUNT - 1);
    case ($urandom_range(9))
      0:          return $urandom_range(1) ? '1 : '0;
      1, 2, 3, 4: return key_times_cfg[TIME_W*k +: TIME_W]
                         + TIME_W'($urandom_range(16)) - TIME_W'(8);
      default:    return TIME_W'($urandom_range(16'hFFFF));
    endcase
  endfunction

  task automatic note_failure(input string what);
    if (failures < REPORT_MAX)
      $display("[%0t] MISMATCH %s", $realtime, what);
    failures++;
  endtask

  // append a word to the send queue
  task automatic queue_fraction(input logic [TIME_W-1:0] fraction);
    pending_fractions = {pending_fractions, fraction};
  endtask

  // append an expected result word
  task automatic queue_expected(input shade_t shade);
    expected_shades = {expected_shades, shade};
  endtask

  // --------------------------------------------------------------------------
  // Input driver: present the next pending word, hold it while stalled, and
  // record its expected result at the edge where it is accepted
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i      <= 1'b0;
      life_fraction_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o)
        queue_expected(predict_shade(life_fraction_i));
      if (!in_valid_i || !in_stall_o) begin
        if (pending_fractions.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i      <= 1'b1;
          life_fraction_i <= pending_fractions.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor: check each accepted word against the oldest expectation,
  // then pick the stall for the next cycle
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    shade_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_shades.size() == 0) begin
          note_failure("result word with nothing expected");
        end else begin
          want = expected_shades.pop_front();
          if (red_o !== want.red || green_o !== want.green || blue_o !== want.blue ||
              alpha_o !== want.alpha || particle_size_o !== want.particle_size)
            note_failure($sformatf(
              "rgba/size expected %02h %02h %02h %02h %04h got %02h %02h %02h %02h %04h",
              want.red, want.green, want.blue, want.alpha, want.particle_size,
              red_o, green_o, blue_o, alpha_o, particle_size_o));
        end
      end
      out_stall_i <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
    end
  end

  // long hold-off of the receiver, counted here so the sender keeps going
  always @(posedge clk_i) begin
    if (hold_left != 0)
      hold_left <= hold_left - 1;
    else if (hold_kick)
      hold_left <= HOLD_CYCLES;
  end

  // watchdog: give up when no handshake of any kind happens for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Configuration access
  // --------------------------------------------------------------------------

  // one APB transfer: setup cycle, then access until pready
  task automatic apb_access(input logic [REG_IDX_W-1:0] idx, input logic wr,
                            input logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_W'({idx, 3'b000});
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // write a register, mirror it in the shadow copy and read it back
  task automatic program_reg(input logic [REG_IDX_W-1:0] idx,
                             input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] seen;
    logic [DATA_W-1:0] mask;
    apb_access(idx, 1'b1, value, seen);
    // unmapped indexes: the write is dropped and there is nothing to read
    if (idx > REG_KEY3_COLOR)
      return;
    mask = (idx >= REG_KEY0_COLOR) ? DATA_W'(32'hFFFF_FFFF) : '1;
    case (idx)
      REG_KEY_TIMES: key_times_cfg = value;
      REG_KEY_SIZES: key_sizes_cfg = value;
      default:       key_color_cfg[idx - REG_KEY0_COLOR] = value[31:0];
    endcase
    apb_access(idx, 1'b0, '0, seen);
    if ((seen & mask) !== (value & mask))
      note_failure($sformatf("register %0d read %h, wrote %h", idx, seen & mask,
                             value & mask));
  endtask

  task automatic apply_keys(input logic [DATA_W-1:0] times, input logic [DATA_W-1:0] sizes,
                            input logic [31:0] c0, input logic [31:0] c1,
                            input logic [31:0] c2, input logic [31:0] c3);
    program_reg(REG_KEY_TIMES, times);
    program_reg(REG_KEY_SIZES, sizes);
    program_reg(REG_KEY0_COLOR, DATA_W'(c0));
    program_reg(REG_KEY1_COLOR, DATA_W'(c1));
    program_reg(REG_KEY2_COLOR, DATA_W'(c2));
    program_reg(REG_KEY3_COLOR, DATA_W'(c3));
  endtask

  // wait, sampling away from the active edge, until every word is back
  task automatic drain_results();
    @(negedge clk_i);
    while (pending_fractions.size() != 0 || in_valid_i || expected_shades.size() != 0)
      @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [TIME_W-1:0] t [KEY_COUNT];
    logic [DATA_W-1:0] times;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset keys: all times zero, so only zero picks key 0
    queue_fraction(16'h0000);
    queue_fraction(16'h0001);
    queue_fraction(16'h8000);
    queue_fraction(16'hFFFF);
    drain_results();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: times = 64'hF000_A000_5000_1000;              // spread, rising
        1: times = 64'hFFFF_8000_4000_0000;              // full range
        2: times = 64'h0120_0071_006A_0064;              // spans of 6 and 7
        3: times = 64'h4000_C000_2000_8000;              // key times out of order
        4: times = 64'h8000_8000_8000_8000;              // all keys at once
        5: times = '1;                                   // every time at 1.0
        6: begin
          t[0] = TIME_W'($urandom_range(16'h3FFF));
          for (int k = 1; k < KEY_COUNT; k++)
            t[k] = t[k-1] + TIME_W'($urandom_range(16'h3FFF));
          times = {t[3], t[2], t[1], t[0]};
        end
        default: times = {$urandom, $urandom};           // any order
      endcase

      case (phase)
        1: apply_keys(times, 64'hFFFF_0000_FFFF_0000,
                      32'h0000_0000, 32'hFFFF_FFFF, 32'h00FF_00FF, 32'hFF00_FF00);
        4: begin
          apply_keys(times, '1, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                     32'h0000_0000);
          // stray writes past the map; results below show they were dropped
          program_reg(REG_UNMAPPED_LO, {$urandom, $urandom});
          program_reg(REG_UNMAPPED_HI, {$urandom, $urandom});
        end
        5: apply_keys(times, '0, $urandom, $urandom, $urandom, $urandom);
        default: apply_keys(times, {$urandom, $urandom},
                            $urandom, $urandom, $urandom, $urandom);
      endcase

      // rotate the idling pattern across phases
      @(negedge clk_i);
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 61; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 61; end
        default: begin send_idle_pct = 20; stall_pct = 20; end
      endcase

      // directed words on the first rising set: each key time, its
      // neighbors, the span midpoints and both ends of the range
      if (phase == 0) begin
        queue_fraction(16'h0000);
        queue_fraction(16'hFFFF);
        for (int k = 0; k < KEY_COUNT; k++) begin
          queue_fraction(key_times_cfg[TIME_W*k +: TIME_W]);
          queue_fraction(key_times_cfg[TIME_W*k +: TIME_W] - 16'd1);
          queue_fraction(key_times_cfg[TIME_W*k +: TIME_W] + 16'd1);
        end
        for (int k = 1; k < KEY_COUNT; k++)
          queue_fraction(TIME_W'((32'(key_times_cfg[TIME_W*(k-1) +: TIME_W])
                                  + 32'(key_times_cfg[TIME_W*k +: TIME_W])) / 2));
      end

      // hold the receiver off while the sender streams, so the pipeline
      // fills and the input stalls
      if (phase == 2) begin
        hold_kick = 1'b1;
        while (hold_left == 0) @(negedge clk_i);
        hold_kick = 1'b0;
      end

      for (int n = 0; n < PHASE_WORDS; n++) begin
        // pause the sender once mid-phase until every result is back
        if (phase == 5 && n == PHASE_WORDS / 2)
          drain_results();
        queue_fraction(pick_fraction());
      end
      drain_results();
    end

    // let any stray word surface before the verdict
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (failures == 0 && expected_shades.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
